[src/skeq_pkg.sv]
// ----------------------------------------------------------------------------
// skeq_pkg
// Types, constants and key tables shared by the scancode key event queue.
// ----------------------------------------------------------------------------
package skeq_pkg;

   // key codes as delivered on the result channel
   typedef enum logic [3:0] {
      KEY_NONE  = 4'd0,
      KEY_W     = 4'd1,
      KEY_A     = 4'd2,
      KEY_S     = 4'd3,
      KEY_D     = 4'd4,
      KEY_UP    = 4'd5,
      KEY_DOWN  = 4'd6,
      KEY_LEFT  = 4'd7,
      KEY_RIGHT = 4'd8,
      KEY_SPACE = 4'd9,
      KEY_ESC   = 4'd10,
      KEY_ENTER = 4'd11,
      KEY_TAB   = 4'd12,
      KEY_LALT  = 4'd13,
      KEY_LCTRL = 4'd14,
      KEY_SHIFT = 4'd15
   } key_code_type;

   // request action codes
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   // scancode bytes
   localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
   localparam logic [7:0] RELEASE_MASK = 8'h80;
   localparam logic [7:0] CODE_MASK    = 8'h7F;

   localparam logic [6:0] SC_W      = 7'h11;
   localparam logic [6:0] SC_A      = 7'h1E;
   localparam logic [6:0] SC_S      = 7'h1F;
   localparam logic [6:0] SC_D      = 7'h20;
   localparam logic [6:0] SC_UP     = 7'h48;
   localparam logic [6:0] SC_DOWN   = 7'h50;
   localparam logic [6:0] SC_LEFT   = 7'h4B;
   localparam logic [6:0] SC_RIGHT  = 7'h4D;
   localparam logic [6:0] SC_SPACE  = 7'h39;
   localparam logic [6:0] SC_ESC    = 7'h01;
   localparam logic [6:0] SC_ENTER  = 7'h1C;
   localparam logic [6:0] SC_TAB    = 7'h0F;
   localparam logic [6:0] SC_LALT   = 7'h38;
   localparam logic [6:0] SC_LCTRL  = 7'h1D;
   localparam logic [6:0] SC_LSHIFT = 7'h2A;
   localparam logic [6:0] SC_RSHIFT = 7'h36;

   // one stored event
   typedef struct packed {
      logic         pressed;
      key_code_type key;
   } key_event_type;

   // command from the decoder to the ring
   typedef struct packed {
      logic          push;
      logic          pop;
      key_event_type ev;
   } ring_cmd_type;

   // normal (unprefixed) key table
   function automatic key_code_type map_normal(input logic [6:0] code);
      key_code_type k;
      unique case (code)
         SC_W:      k = KEY_W;
         SC_A:      k = KEY_A;
         SC_S:      k = KEY_S;
         SC_D:      k = KEY_D;
         SC_UP:     k = KEY_UP;
         SC_DOWN:   k = KEY_DOWN;
         SC_LEFT:   k = KEY_LEFT;
         SC_RIGHT:  k = KEY_RIGHT;
         SC_SPACE:  k = KEY_SPACE;
         SC_ESC:    k = KEY_ESC;
         SC_ENTER:  k = KEY_ENTER;
         SC_TAB:    k = KEY_TAB;
         SC_LALT:   k = KEY_LALT;
         SC_LCTRL:  k = KEY_LCTRL;
         SC_LSHIFT: k = KEY_SHIFT;
         SC_RSHIFT: k = KEY_SHIFT;
         default:   k = KEY_NONE;
      endcase
      return k;
   endfunction

   // extended (prefixed) key table: arrows only
   function automatic key_code_type map_extended(input logic [6:0] code);
      key_code_type k;
      unique case (code)
         SC_UP:    k = KEY_UP;
         SC_DOWN:  k = KEY_DOWN;
         SC_LEFT:  k = KEY_LEFT;
         SC_RIGHT: k = KEY_RIGHT;
         default:  k = KEY_NONE;
      endcase
      return k;
   endfunction

endpackage

[src/skeq_if.sv]
// ----------------------------------------------------------------------------
// skeq request and response channels
// Valid/ready channels carrying scancode requests and key event responses.
// ----------------------------------------------------------------------------
interface skeq_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] scan_byte;

   modport source (output valid, output action, output scan_byte, input ready);
   modport sink   (input valid, input action, input scan_byte, output ready);
endinterface

interface skeq_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_valid;
   logic [3:0] key_code;
   logic       key_pressed;
   logic       events_pending;

   modport source (output valid, output event_valid, output key_code,
                   output key_pressed, output events_pending, input ready);
   modport sink   (input valid, input event_valid, input key_code,
                   input key_pressed, input events_pending, output ready);
endinterface

[src/skeq_decode.sv]
// ----------------------------------------------------------------------------
// skeq_decode
// Set-1 scancode decoder with extended-prefix tracking; builds ring commands.
// ----------------------------------------------------------------------------
module skeq_decode
   import skeq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         action,
   input  logic [7:0]   scan_byte,
   output ring_cmd_type cmd
);

   logic         prefix_ff;
   logic         prefix_in;
   logic         is_prefix;
   logic [6:0]   code;
   key_code_type key;

   // classify the byte and look up the key
   always_comb begin
      is_prefix = (scan_byte == PREFIX_BYTE);
      code      = 7'(scan_byte & CODE_MASK);
      key       = prefix_ff ? map_extended(code) : map_normal(code);
   end

   // ring command
   always_comb begin
      cmd.push       = (action == ACTION_BYTE) && !is_prefix && (key != KEY_NONE);
      cmd.pop        = (action == ACTION_POP);
      cmd.ev.key     = key;
      cmd.ev.pressed = ((scan_byte & RELEASE_MASK) == 8'h00);
   end

   // prefix flag: set by the prefix byte, cleared by any other byte
   always_comb begin
      prefix_in = prefix_ff;
      if (advance && (action == ACTION_BYTE)) begin
         prefix_in = is_prefix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
      end
   end

endmodule

[src/skeq_ring.sv]
// ----------------------------------------------------------------------------
// skeq_ring
// Event ring buffer; drops pushes when full and reads the oldest on pop.
// ----------------------------------------------------------------------------
module skeq_ring
   import skeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  ring_cmd_type  cmd,
   output logic          pop_hit,
   output logic          pending,
   output key_event_type rd_event_ff
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   key_event_type    store [QUEUE_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, wp_next;
   logic [PTR_W-1:0] rp_ff, rp_in, rp_next;
   logic             empty, full;
   logic             do_push, do_pop;

   // pointer arithmetic with wrap at the depth
   always_comb begin
      wp_next = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
      rp_next = (rp_ff == LAST_SLOT) ? '0 : rp_ff + 1'b1;
      empty   = (wp_ff == rp_ff);
      full    = (wp_next == rp_ff);
      do_push = advance && cmd.push && !full;
      do_pop  = advance && cmd.pop && !empty;
      pop_hit = cmd.pop && !empty;
      wp_in   = do_push ? wp_next : wp_ff;
      rp_in   = do_pop ? rp_next : rp_ff;
      pending = (wp_in != rp_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   // event storage, registered read
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wp_ff] <= cmd.ev;
      end
      if (do_pop) begin
         rd_event_ff <= store[rp_ff];
      end
   end

endmodule

[src/scancode_key_event_queue.sv]
// ----------------------------------------------------------------------------
// scancode_key_event_queue
// Set-1 scancode decoder feeding a key event ring with pop requests.
//
//   channel  | dir | payload
//   ---------+-----+----------------------------------------------------
//   req_ch   | in  | action, scan_byte
//   rsp_ch   | out | event_valid, key_code, key_pressed, events_pending
//
// One request per cycle while responses are taken, one response per request,
// through an input register, then decode and ring update into the response register.
// The ring read port is registered alongside the response register.
// Reset clears the prefix flag, the ring pointers and both stage valids.
// A stalled response holds both stages; requests resume as it is taken.
// ----------------------------------------------------------------------------
module scancode_key_event_queue
   import skeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
)
(
   input  logic              clock,
   input  logic              reset,
   skeq_req_if.sink          req_ch,
   skeq_rsp_if.source        rsp_ch
);

   logic          in_valid_ff;
   logic          in_action_ff;
   logic [7:0]    in_byte_ff;
   logic          advance;
   logic          in_load;
   ring_cmd_type  cmd;
   logic          pop_hit;
   logic          pending;
   key_event_type rd_event_ff;
   logic          rsp_valid_ff;
   logic          event_valid_ff;
   logic          pending_ff;

   // stage control
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_load      = req_ch.valid && req_ch.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_action_ff <= req_ch.action;
         in_byte_ff   <= req_ch.scan_byte;
      end
   end

   skeq_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .action    (in_action_ff),
      .scan_byte (in_byte_ff),
      .cmd       (cmd)
   );

   skeq_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cmd         (cmd),
      .pop_hit     (pop_hit),
      .pending     (pending),
      .rd_event_ff (rd_event_ff)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_valid_ff <= pop_hit;
         pending_ff     <= pending;
      end
   end

   // response payload, event fields zero unless a pop returned one
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.event_valid    = event_valid_ff;
   assign rsp_ch.key_code       = event_valid_ff ? rd_event_ff.key : KEY_NONE;
   assign rsp_ch.key_pressed    = event_valid_ff && rd_event_ff.pressed;
   assign rsp_ch.events_pending = pending_ff;

endmodule

[src/skeq_checker.sv]
// ----------------------------------------------------------------------------
// skeq_checker
// Port-level checks for the scancode key event queue, bound to the top level.
// ----------------------------------------------------------------------------
module skeq_checker
   import skeq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_event_valid,
   input logic [3:0] rsp_key_code,
   input logic       rsp_key_pressed,
   input logic       rsp_events_pending
);

   // no response is shown right after reset
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response keeps its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_event_valid)
         && $stable(rsp_key_code) && $stable(rsp_key_pressed)
         && $stable(rsp_events_pending)))
      else $error("stalled response changed");

   // a returned event always names a key
   a_event_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_valid) |-> (rsp_key_code != KEY_NONE))
      else $error("event without key code");

   // without an event the key fields are zero
   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_event_valid)
         |-> (rsp_key_code == KEY_NONE && !rsp_key_pressed))
      else $error("key fields set without event");

endmodule

bind scancode_key_event_queue skeq_checker u_skeq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_event_valid    (rsp_ch.event_valid),
   .rsp_key_code       (rsp_ch.key_code),
   .rsp_key_pressed    (rsp_ch.key_pressed),
   .rsp_events_pending (rsp_ch.events_pending)
);

[tb/skeq_response_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skeq_response_checker
// Watches the request and response channels of the scancode key event queue.
// Keeps its own copy of the prefix flag and the event ring, predicts one
// response for every request transfer and compares each response transfer
// against the oldest prediction. Hands a mismatch count and the number of
// responses still awaited to the testbench top.
// ----------------------------------------------------------------------------
module skeq_response_checker
   import skeq_pkg::*;
#(
   parameter int RING_SLOTS = 64
)
(
   input  logic clock,
   input  logic reset,
   skeq_req_if  req_ch,
   skeq_rsp_if  rsp_ch,
   output int   awaited_count,
   output int   mismatch_count
);

   typedef struct packed {
      logic         event_valid;
      key_code_type key_code;
      logic         key_pressed;
      logic         events_pending;
   } key_response_type;

   // decode tables indexed by the 7-bit scancode
   key_code_type plain_keys [128];
   key_code_type arrow_keys [128];

   // shadow of the block state
   logic          prefix_armed;
   key_event_type ring_shadow [RING_SLOTS];
   int unsigned   ring_wr;
   int unsigned   ring_rd;

   key_response_type awaited_responses [$];
   key_response_type seen;
   key_response_type oldest;
   int               fail_tally;

   assign mismatch_count = fail_tally;

   // table setup
   initial begin
      fail_tally = 0;
      awaited_count = 0;
      foreach (plain_keys[i]) begin
         plain_keys[i] = KEY_NONE;
         arrow_keys[i] = KEY_NONE;
      end
      plain_keys[SC_W]      = KEY_W;
      plain_keys[SC_A]      = KEY_A;
      plain_keys[SC_S]      = KEY_S;
      plain_keys[SC_D]      = KEY_D;
      plain_keys[SC_UP]     = KEY_UP;
      plain_keys[SC_DOWN]   = KEY_DOWN;
      plain_keys[SC_LEFT]   = KEY_LEFT;
      plain_keys[SC_RIGHT]  = KEY_RIGHT;
      plain_keys[SC_SPACE]  = KEY_SPACE;
      plain_keys[SC_ESC]    = KEY_ESC;
      plain_keys[SC_ENTER]  = KEY_ENTER;
      plain_keys[SC_TAB]    = KEY_TAB;
      plain_keys[SC_LALT]   = KEY_LALT;
      plain_keys[SC_LCTRL]  = KEY_LCTRL;
      plain_keys[SC_LSHIFT] = KEY_SHIFT;
      plain_keys[SC_RSHIFT] = KEY_SHIFT;
      arrow_keys[SC_UP]     = KEY_UP;
      arrow_keys[SC_DOWN]   = KEY_DOWN;
      arrow_keys[SC_LEFT]   = KEY_LEFT;
      arrow_keys[SC_RIGHT]  = KEY_RIGHT;
   end

   // advance the shadow state by one request and return its response
   function automatic key_response_type predict_key_response(input logic act,
                                                             input logic [7:0] b);
      key_response_type r;
      key_code_type     k;
      logic [6:0]       code;
      r = '0;
      code = b[6:0];
      if (act == ACTION_BYTE) begin
         if (b == PREFIX_BYTE) begin
            // prefix arms the flag even when already armed
            prefix_armed = 1'b1;
         end else begin
            k = prefix_armed ? arrow_keys[code] : plain_keys[code];
            prefix_armed = 1'b0;
            // a full ring drops the event, so one slot always stays free
            if (k != KEY_NONE && (ring_wr + 1) % RING_SLOTS != ring_rd) begin
               ring_shadow[ring_wr].key = k;
               ring_shadow[ring_wr].pressed = ((b & RELEASE_MASK) == 8'h00);
               ring_wr = (ring_wr + 1) % RING_SLOTS;
            end
         end
      end else if (ring_wr != ring_rd) begin
         r.event_valid = 1'b1;
         r.key_code = ring_shadow[ring_rd].key;
         r.key_pressed = ring_shadow[ring_rd].pressed;
         ring_rd = (ring_rd + 1) % RING_SLOTS;
      end
      r.events_pending = (ring_wr != ring_rd);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input key_response_type exp,
                                input key_response_type got);
      fail_tally++;
      if (fail_tally <= 10)
         $display("%0t mismatch (%s): expected valid=%0b key=%0d pressed=%0b pending=%0b,",
                  $realtime, what, exp.event_valid, exp.key_code, exp.key_pressed,
                  exp.events_pending,
                  " got valid=%0b key=%0d pressed=%0b pending=%0b",
                  got.event_valid, got.key_code, got.key_pressed,
                  got.events_pending);
   endtask

   // channel monitor
   always @(posedge clock) begin
      if (reset) begin
         prefix_armed = 1'b0;
         ring_wr = 0;
         ring_rd = 0;
         awaited_responses.delete();
         awaited_count <= 0;
      end else begin
         // response transfer: compare with the oldest prediction
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen.event_valid = rsp_ch.event_valid;
            seen.key_code = key_code_type'(rsp_ch.key_code);
            seen.key_pressed = rsp_ch.key_pressed;
            seen.events_pending = rsp_ch.events_pending;
            if (awaited_responses.size() == 0) begin
               note_mismatch("no response awaited", '0, seen);
            end else begin
               oldest = awaited_responses.pop_front();
               if (seen.event_valid !== oldest.event_valid ||
                   seen.key_code !== oldest.key_code ||
                   seen.key_pressed !== oldest.key_pressed ||
                   seen.events_pending !== oldest.events_pending)
                  note_mismatch("field", oldest, seen);
            end
         end
         // request transfer: predict its response
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            awaited_responses.push_back(predict_key_response(req_ch.action,
                                                             req_ch.scan_byte));
         awaited_count <= awaited_responses.size();
      end
   end

endmodule

[tb/scancode_key_event_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_key_event_queue_test
// Drives scancode bytes and pop requests into the key event queue: a short
// directed run over the key tables, prefix handling and the empty ring, then
// random traffic that alternates between fill-heavy and drain-heavy
// stretches, under three sender/receiver idling mixes. Responses are
// checked by the response checker.
// ----------------------------------------------------------------------------
module scancode_key_event_queue_test;
   import skeq_pkg::*;

   localparam int RING_SLOTS  = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 250;

   localparam logic [6:0] KEY_SCANCODES [16] = '{
      SC_W, SC_A, SC_S, SC_D, SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT,
      SC_SPACE, SC_ESC, SC_ENTER, SC_TAB, SC_LALT, SC_LCTRL, SC_LSHIFT, SC_RSHIFT
   };

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   awaited_count;
   int   mismatch_count;
   int   cycle_count;

   skeq_req_if req_ch ();
   skeq_rsp_if rsp_ch ();

   scancode_key_event_queue #(
      .QUEUE_DEPTH (RING_SLOTS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   skeq_response_checker #(
      .RING_SLOTS (RING_SLOTS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .awaited_count  (awaited_count),
      .mismatch_count (mismatch_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // receiver stalls
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_request(input logic act, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.scan_byte <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // hold the sender off until every response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   // random traffic: fill-heavy and drain-heavy stretches
   task automatic send_random_traffic(input int count);
      int         made;
      int         roll;
      int         pop_pct;
      logic [7:0] b;
      made = 0;
      while (made < count) begin
         pop_pct = ((made / 90) % 2 == 0) ? 4 : 55;
         roll = $urandom_range(99);
         if (roll < pop_pct) begin
            send_request(ACTION_POP, 8'($urandom_range(255)));
            made++;
         end else begin
            roll = $urandom_range(99);
            if (roll < 55) begin
               // mapped key, press or release
               b = {1'($urandom_range(1)), KEY_SCANCODES[$urandom_range(15)]};
               send_request(ACTION_BYTE, b);
               made++;
            end else if (roll < 80) begin
               // prefixed sequence, sometimes with a doubled prefix
               send_request(ACTION_BYTE, PREFIX_BYTE);
               made++;
               if ($urandom_range(3) == 0) begin
                  send_request(ACTION_BYTE, PREFIX_BYTE);
                  made++;
               end
               if ($urandom_range(3) != 0)
                  b = {1'($urandom_range(1)), KEY_SCANCODES[$urandom_range(7, 4)]};
               else
                  b = 8'($urandom_range(255));
               send_request(ACTION_BYTE, b);
               made++;
            end else begin
               // any byte at all
               send_request(ACTION_BYTE, 8'($urandom_range(255)));
               made++;
            end
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.action <= ACTION_BYTE;
      req_ch.scan_byte <= 8'h00;
      send_idle_pct = 20;
      recv_idle_pct = 67;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, press/release, prefixes, unmapped bytes, drain
      send_request(ACTION_POP, 8'hFF);
      send_request(ACTION_BYTE, {1'b0, SC_W});
      send_request(ACTION_BYTE, {1'b1, SC_W});
      send_request(ACTION_BYTE, PREFIX_BYTE);
      send_request(ACTION_BYTE, PREFIX_BYTE);
      send_request(ACTION_BYTE, {1'b0, SC_UP});
      send_request(ACTION_BYTE, PREFIX_BYTE);
      send_request(ACTION_BYTE, {1'b1, SC_RIGHT});
      send_request(ACTION_BYTE, PREFIX_BYTE);
      send_request(ACTION_BYTE, {1'b0, SC_W});
      send_request(ACTION_BYTE, {1'b0, SC_W});
      send_request(ACTION_BYTE, {1'b0, SC_DOWN});
      send_request(ACTION_BYTE, 8'h00);
      send_request(ACTION_BYTE, 8'hFF);
      send_request(ACTION_BYTE, {1'b0, SC_RSHIFT});
      send_request(ACTION_BYTE, {1'b1, SC_LSHIFT});
      send_request(ACTION_BYTE, RELEASE_MASK);
      repeat (8) send_request(ACTION_POP, 8'h00);
      wait_drained();

      // random traffic under three idling mixes
      send_random_traffic(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 67;
      recv_idle_pct = 20;
      send_random_traffic(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_traffic(PHASE_ITEMS);
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && awaited_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
